>>> hdl/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int CFG_W          = 5;
    localparam int PAGE_W         = 16;
    localparam int SLOT_W         = 4;
    localparam int FAULT_W        = 32;
    localparam int IDX_MAX_W      = 6;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                 hit;
        logic [IDX_MAX_W-1:0] hit_idx;
        logic [IDX_MAX_W-1:0] hit_rank;
        logic                 found;
        logic [IDX_MAX_W-1:0] empty_idx;
        logic [IDX_MAX_W-1:0] vic_idx;
        logic [IDX_MAX_W-1:0] vic_rank;
        logic [PAGE_W-1:0]    vic_page;
    } t_scan_res;

endpackage

>>> hdl/lrupr_if.sv
`timescale 1ns / 1ps

interface lrupr_in_if import lrupr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;

    modport source (output valid, page_number, last_reference, input ready);
    modport sink   (input valid, page_number, last_reference, output ready);
endinterface

interface lrupr_out_if import lrupr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;
    logic               string_done;

    modport source (output valid, hit, slot, evicted_valid, evicted_page, fault_count,
                    string_done, input ready);
    modport sink   (input valid, hit, slot, evicted_valid, evicted_page, fault_count,
                    string_done, output ready);
endinterface

interface lrupr_cfg_if import lrupr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hdl/lrupr_scan.sv
`timescale 1ns / 1ps

module lrupr_scan import lrupr_pkg::*; #(
    parameter int IDX_W = 4,
    parameter int PG_W  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_beat,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_active,
    input  logic             i_frame_valid,
    input  logic [PG_W-1:0]  i_frame_page,
    input  logic [IDX_W-1:0] i_rank,
    input  logic [PG_W-1:0]  i_ref_page,
    output t_scan_res        o_res
);

    t_scan_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.hit   <= 1'b0;
            r_res.found <= 1'b0;
        end else if (i_start) begin
            r_res.hit   <= 1'b0;
            r_res.found <= 1'b0;
        end else if (i_beat && i_active) begin
            // lowest matching frame wins
            if (!r_res.hit && i_frame_valid && (i_frame_page == i_ref_page)) begin
                r_res.hit      <= 1'b1;
                r_res.hit_idx  <= IDX_MAX_W'(i_idx);
                r_res.hit_rank <= IDX_MAX_W'(i_rank);
            end
            if (!r_res.found && !i_frame_valid) begin
                r_res.found     <= 1'b1;
                r_res.empty_idx <= IDX_MAX_W'(i_idx);
            end
            // oldest frame, only used when every active frame is valid
            if ((i_idx == '0) || (IDX_MAX_W'(i_rank) > r_res.vic_rank)) begin
                r_res.vic_idx  <= IDX_MAX_W'(i_idx);
                r_res.vic_rank <= IDX_MAX_W'(i_rank);
                r_res.vic_page <= PAGE_W'(i_frame_page);
            end
        end
    end

    assign o_res = r_res;

endmodule

>>> hdl/lru_page_replacement_top.sv
`timescale 1ns / 1ps

// sequence: each accepted reference takes a match/victim scan pass and then a rank
//   write-back pass over the frame memory, then a finish state that registers the
//   output beat; the next input beat is accepted only once the sequencer is back in idle
// a waiting output beat does not block the next input beat
// reset: synchronous active-low; valid bits and fault count clear, active frames = 16

module lru_page_replacement_top import lrupr_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrupr_in_if.sink    i_in,
    lrupr_out_if.source o_out,
    lrupr_cfg_if.sink   i_cfg
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int MW = PW + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_FRAMES - 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]      r_active;
    logic [MAX_FRAMES-1:0] r_valid;
    logic [FAULT_W-1:0]    r_faults;
    logic [PW-1:0]         r_ref_page;
    logic                  r_last;
    logic [IW-1:0]         r_idx;

    logic [MW-1:0] mem [MAX_FRAMES];
    logic [MW-1:0] r_rd_data;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic          r_rd_upd;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_ev_valid;
    logic [PAGE_W-1:0]     r_out_ev_page;
    logic                  r_out_done;

    logic          w_accept;
    logic          w_rd_en;
    logic          w_rd_upd;
    logic          w_fin_go;
    logic          w_wr_en;
    logic [CW-1:0] w_n;
    logic [PW-1:0] w_mem_page;
    logic [IW-1:0] w_mem_rank;
    logic [IW-1:0] w_slot;
    logic [IW-1:0] w_lim;
    logic          w_age_all;
    logic          w_evict;
    logic          w_miss;
    logic          w_age;
    logic [MW-1:0] w_wr_data;
    t_scan_res     w_res;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg.valid) begin
            r_active <= i_cfg.data;
        end
    end

    always_comb begin
        if (r_active == '0) begin
            w_n = CW'(1);
        end else if (32'(r_active) > 32'(MAX_FRAMES)) begin
            w_n = CW'(MAX_FRAMES);
        end else begin
            w_n = CW'(r_active);
        end
    end

    // sequencer
    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        w_rd_en  = 1'b0;
        w_rd_upd = 1'b0;
        w_fin_go = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                w_rd_en  = 1'b1;
                w_rd_upd = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    w_fin_go = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ref_page <= i_in.page_number[PW-1:0];
            r_last     <= i_in.last_reference;
        end
        if (w_accept || (w_rd_en && (r_idx == LAST_IDX))) begin
            r_idx <= '0;
        end else if (w_rd_en) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // frame memory: page and rank per frame
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[r_idx];
        end
        if (w_wr_en) begin
            mem[r_rd_idx] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_rd_upd <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_en;
            r_rd_upd <= w_rd_upd;
        end
        r_rd_idx <= r_idx;
    end

    assign w_mem_page = r_rd_data[MW-1:IW];
    assign w_mem_rank = r_rd_data[IW-1:0];

    lrupr_scan #(
        .IDX_W (IW),
        .PG_W  (PW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_accept),
        .i_beat        (r_rd_vld && !r_rd_upd),
        .i_idx         (r_rd_idx),
        .i_active      (CW'(r_rd_idx) < w_n),
        .i_frame_valid (r_valid[r_rd_idx]),
        .i_frame_page  (w_mem_page),
        .i_rank        (w_mem_rank),
        .i_ref_page    (r_ref_page),
        .o_res         (w_res)
    );

    // replacement decision
    always_comb begin
        w_miss    = !w_res.hit;
        w_evict   = !w_res.hit && !w_res.found;
        w_age_all = !w_res.hit && w_res.found;
        if (w_res.hit) begin
            w_slot = IW'(w_res.hit_idx);
            w_lim  = IW'(w_res.hit_rank);
        end else if (w_res.found) begin
            w_slot = IW'(w_res.empty_idx);
            w_lim  = IW'(w_res.vic_rank);
        end else begin
            w_slot = IW'(w_res.vic_idx);
            w_lim  = IW'(w_res.vic_rank);
        end
    end

    // rank write-back pass
    assign w_wr_en = r_rd_vld && r_rd_upd;
    assign w_age   = r_valid[r_rd_idx] && (w_age_all || (w_mem_rank < w_lim));

    always_comb begin
        if (r_rd_idx == w_slot) begin
            w_wr_data = {r_ref_page, {IW{1'b0}}};
        end else if (w_age) begin
            w_wr_data = {w_mem_page, w_mem_rank + 1'b1};
        end else begin
            w_wr_data = r_rd_data;
        end
    end

    // valid bits and fault count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_faults <= '0;
        end else if (w_fin_go) begin
            if (r_last) begin
                r_valid  <= '0;
                r_faults <= '0;
            end else if (w_miss) begin
                r_valid[w_slot] <= 1'b1;
                if (r_faults != '1) begin
                    r_faults <= r_faults + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    logic [FAULT_W-1:0] r_out_faults;

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out_hit      <= w_res.hit;
            r_out_slot     <= SLOT_W'(w_slot);
            r_out_ev_valid <= w_evict;
            r_out_ev_page  <= w_evict ? w_res.vic_page : '0;
            r_out_done     <= r_last;
            if (w_miss && (r_faults != '1)) begin
                r_out_faults <= r_faults + 1'b1;
            end else begin
                r_out_faults <= r_faults;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_out_hit;
    assign o_out.slot          = r_out_slot;
    assign o_out.evicted_valid = r_out_ev_valid;
    assign o_out.evicted_page  = r_out_ev_page;
    assign o_out.fault_count   = r_out_faults;
    assign o_out.string_done   = r_out_done;

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FINISH))
        else $error("output beat raised outside finish");

    a_fill_adds_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && !r_last && w_age_all) |=>
            ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("fill did not add exactly one valid frame");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && r_last) |=> ((r_valid == '0) && (r_faults == '0)))
        else $error("table not cleared after last reference");

endmodule
